// File: sv/adfe_pkg.sv
// ----------------------------------------------------------------------------
// adfe_pkg
// Shared constants for the advertising data field extractor: AD type codes,
// field widths and UUID size.
// ----------------------------------------------------------------------------
package adfe_pkg;

   localparam int ByteW    = 8;
   localparam int NameLenW = 5;
   localparam int UuidW    = 64;
   localparam int UuidBytes = 16;
   localparam int UuidIdxW = 4;
   localparam int NameHwCap = 31;

   // AD structure type codes
   localparam logic [ByteW-1:0] AdTypeUuid128Part  = 8'h06;
   localparam logic [ByteW-1:0] AdTypeUuid128Full  = 8'h07;
   localparam logic [ByteW-1:0] AdTypeNameShort    = 8'h08;
   localparam logic [ByteW-1:0] AdTypeNameComplete = 8'h09;

   // structure length needed to hold a type byte and a full 128-bit UUID
   localparam logic [ByteW-1:0] UuidMinLen = 8'(UuidBytes + 1);
   localparam logic [ByteW-1:0] PayloadMax = 8'hFF;

   typedef logic [UuidBytes-1:0][ByteW-1:0] uuid_type;

endpackage

// File: sv/adv_data_field_extractor_unit.sv
// ----------------------------------------------------------------------------
// adv_data_field_extractor_unit
// Streaming parser for advertising data: walks length-type-value structures,
// captures the first local name and the first 128-bit service UUID, and
// reports a summary request followed by the name bytes at payload end.
// ----------------------------------------------------------------------------
// Output: the summary request is valid in the cycle after the last payload byte
//   is accepted; name-byte requests follow at one per cycle when rsp_ready.
// Throughput: one payload byte per cycle. The name store is ping-ponged, so the
//   next payload streams in while the previous result run drains; only a last
//   byte waits, until every name read of the previous run has been issued and
//   the output register is free to take the summary.
// Reset: synchronous, active high; clears the parser and the result channel.
// ----------------------------------------------------------------------------
module adv_data_field_extractor_unit
   import adfe_pkg::*;
#(
   parameter int NAME_CAP = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ByteW-1:0]    req_adv_byte,
   input  logic                req_last_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_is_name_byte,
   output logic                rsp_name_found,
   output logic [NameLenW-1:0] rsp_name_length,
   output logic                rsp_uuid_found,
   output logic [UuidW-1:0]    rsp_uuid_low,
   output logic [UuidW-1:0]    rsp_uuid_high,
   output logic [ByteW-1:0]    rsp_name_byte,
   output logic                rsp_last_result
);

   // name bytes kept per payload, limited by the name_length field width
   localparam int NameKeep = (NAME_CAP - 1 > NameHwCap) ? NameHwCap : NAME_CAP - 1;
   localparam int NameAw   = (NameKeep > 1) ? $clog2(NameKeep) : 1;
   localparam int MemAw    = NameAw + 1;
   localparam int MemDepth = 1 << MemAw;

   // ------------------------------------------------------------------------
   // parser state
   // ------------------------------------------------------------------------
   logic [ByteW-1:0]    remain_ff, remain_in;
   logic [ByteW-1:0]    len_ff, len_in;
   logic [ByteW-1:0]    typ_ff, typ_in;
   logic [ByteW-1:0]    seen_ff, seen_in;
   logic [NameLenW-1:0] name_cnt_ff, name_cnt_in;
   logic                name_done_ff, name_done_in;
   uuid_type            uuid_ff, uuid_in;
   logic                uuid_done_ff, uuid_done_in;
   logic                uuid_halt_ff, uuid_halt_in;
   logic                wbank_ff, wbank_in;

   // values after the current byte, before the end-of-payload clear
   logic [ByteW-1:0]    upd_remain, upd_len, upd_typ, upd_seen;
   logic [NameLenW-1:0] upd_name_cnt;
   logic                upd_name_done, upd_uuid_done, upd_uuid_halt;
   uuid_type            upd_uuid;

   // ------------------------------------------------------------------------
   // result run state
   // ------------------------------------------------------------------------
   logic                rsp_valid_ff, rsp_valid_in;
   logic                is_name_ff, is_name_in;
   logic                last_res_ff, last_res_in;
   logic [NameLenW-1:0] drain_left_ff, drain_left_in;
   logic [NameAw-1:0]   drain_idx_ff, drain_idx_in;
   logic                rbank_ff, rbank_in;
   logic                snap_name_found_ff;
   logic [NameLenW-1:0] snap_name_len_ff;
   logic                snap_uuid_found_ff;
   uuid_type            snap_uuid_ff;
   logic                snap_load;

   // name store: two banks, one filling while the other drains
   logic [ByteW-1:0]    name_mem [MemDepth];
   logic [ByteW-1:0]    rd_data_ff;
   logic                name_wr_en;
   logic [MemAw-1:0]    name_wr_addr;
   logic                name_rd_en;
   logic [MemAw-1:0]    name_rd_addr;

   logic                req_fire, take, out_adv;
   logic [ByteW-1:0]    offset, k, typ_eff, len_m1;
   logic                name_cand, uuid_cand;

   assign out_adv   = !rsp_valid_ff || rsp_ready;
   // hold a last byte until the previous run has issued all of its name reads
   assign req_ready = !req_last_byte || (drain_left_ff == '0 && out_adv);
   assign req_fire  = req_valid && req_ready;
   // bytes past the 255th are dropped, but their last mark still counts
   assign take      = req_fire && (seen_ff != PayloadMax);

   // ------------------------------------------------------------------------
   // structure walker
   // ------------------------------------------------------------------------
   always_comb begin
      upd_remain    = remain_ff;
      upd_len       = len_ff;
      upd_typ       = typ_ff;
      upd_seen      = seen_ff;
      upd_name_cnt  = name_cnt_ff;
      upd_name_done = name_done_ff;
      upd_uuid      = uuid_ff;
      upd_uuid_done = uuid_done_ff;
      upd_uuid_halt = uuid_halt_ff;
      name_wr_en    = 1'b0;

      offset    = len_ff - remain_ff;
      k         = offset - 8'd1;
      len_m1    = len_ff - 8'd1;
      typ_eff   = (offset == '0) ? req_adv_byte : typ_ff;
      name_cand = !name_done_ff && len_ff > 8'd1 &&
                  (typ_eff == AdTypeNameShort || typ_eff == AdTypeNameComplete);
      uuid_cand = !uuid_done_ff && !uuid_halt_ff && len_ff >= UuidMinLen &&
                  (typ_eff == AdTypeUuid128Part || typ_eff == AdTypeUuid128Full);

      if (take) begin
         upd_seen = seen_ff + 8'd1;
         if (remain_ff == '0) begin
            // length byte: zero ends the UUID search for this payload
            if (req_adv_byte == '0) begin
               upd_uuid_halt = 1'b1;
            end else begin
               upd_len    = req_adv_byte;
               upd_remain = req_adv_byte;
            end
         end else begin
            upd_typ    = typ_eff;
            upd_remain = remain_ff - 8'd1;
            if (offset != '0) begin
               if (name_cand && k < 8'(NameKeep)) begin
                  name_wr_en = 1'b1;
               end
               if (uuid_cand && k < 8'(UuidBytes)) begin
                  upd_uuid[k[UuidIdxW-1:0]] = req_adv_byte;
               end
            end
            // commit a structure only once its final byte is in
            if (remain_ff == 8'd1) begin
               if (name_cand) begin
                  upd_name_done = 1'b1;
                  upd_name_cnt  = (len_m1 > 8'(NameKeep)) ? NameLenW'(NameKeep)
                                                          : len_m1[NameLenW-1:0];
               end
               if (uuid_cand) begin
                  upd_uuid_done = 1'b1;
               end
            end
         end
      end
   end

   assign name_wr_addr = {wbank_ff, k[NameAw-1:0]};

   // end of payload: snapshot the results and clear the walker
   assign snap_load = req_fire && req_last_byte;

   always_comb begin
      if (snap_load) begin
         remain_in    = '0;
         len_in       = '0;
         typ_in       = '0;
         seen_in      = '0;
         name_cnt_in  = '0;
         name_done_in = 1'b0;
         uuid_in      = '0;
         uuid_done_in = 1'b0;
         uuid_halt_in = 1'b0;
         wbank_in     = !wbank_ff;
      end else begin
         remain_in    = upd_remain;
         len_in       = upd_len;
         typ_in       = upd_typ;
         seen_in      = upd_seen;
         name_cnt_in  = upd_name_cnt;
         name_done_in = upd_name_done;
         uuid_in      = upd_uuid;
         uuid_done_in = upd_uuid_done;
         uuid_halt_in = upd_uuid_halt;
         wbank_in     = wbank_ff;
      end
   end

   // ------------------------------------------------------------------------
   // result sequencer: summary first, then one name byte per request
   // ------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      is_name_in    = is_name_ff;
      last_res_in   = last_res_ff;
      drain_left_in = drain_left_ff;
      drain_idx_in  = drain_idx_ff;
      rbank_in      = rbank_ff;
      name_rd_en    = 1'b0;
      if (out_adv) begin
         priority if (drain_left_ff != '0) begin
            // advance to the next name byte
            rsp_valid_in  = 1'b1;
            is_name_in    = 1'b1;
            last_res_in   = (drain_left_ff == NameLenW'(1));
            name_rd_en    = 1'b1;
            drain_left_in = drain_left_ff - NameLenW'(1);
            drain_idx_in  = drain_idx_ff + NameAw'(1);
         end else if (snap_load) begin
            rsp_valid_in  = 1'b1;
            is_name_in    = 1'b0;
            last_res_in   = (upd_name_cnt == '0);
            drain_left_in = upd_name_cnt;
            drain_idx_in  = '0;
            rbank_in      = wbank_ff;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   assign name_rd_addr = {rbank_ff, drain_idx_ff};

   always_ff @(posedge clock) begin
      if (name_wr_en) begin
         name_mem[name_wr_addr] <= req_adv_byte;
      end
      if (name_rd_en) begin
         rd_data_ff <= name_mem[name_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (snap_load) begin
         snap_name_found_ff <= upd_name_done;
         snap_name_len_ff   <= upd_name_done ? upd_name_cnt : '0;
         snap_uuid_found_ff <= upd_uuid_done;
         snap_uuid_ff       <= upd_uuid_done ? upd_uuid : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff     <= '0;
         len_ff        <= '0;
         typ_ff        <= '0;
         seen_ff       <= '0;
         name_cnt_ff   <= '0;
         name_done_ff  <= 1'b0;
         uuid_ff       <= '0;
         uuid_done_ff  <= 1'b0;
         uuid_halt_ff  <= 1'b0;
         wbank_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         is_name_ff    <= 1'b0;
         last_res_ff   <= 1'b0;
         drain_left_ff <= '0;
         drain_idx_ff  <= '0;
         rbank_ff      <= 1'b0;
      end else begin
         remain_ff     <= remain_in;
         len_ff        <= len_in;
         typ_ff        <= typ_in;
         seen_ff       <= seen_in;
         name_cnt_ff   <= name_cnt_in;
         name_done_ff  <= name_done_in;
         uuid_ff       <= uuid_in;
         uuid_done_ff  <= uuid_done_in;
         uuid_halt_ff  <= uuid_halt_in;
         wbank_ff      <= wbank_in;
         rsp_valid_ff  <= rsp_valid_in;
         is_name_ff    <= is_name_in;
         last_res_ff   <= last_res_in;
         drain_left_ff <= drain_left_in;
         drain_idx_ff  <= drain_idx_in;
         rbank_ff      <= rbank_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_name_byte = is_name_ff;
   assign rsp_last_result  = last_res_ff;
   assign rsp_name_found   = snap_name_found_ff;
   assign rsp_name_length  = snap_name_len_ff;
   assign rsp_uuid_found   = snap_uuid_found_ff;
   assign rsp_uuid_low     = snap_uuid_ff[7:0];
   assign rsp_uuid_high    = snap_uuid_ff[15:8];
   assign rsp_name_byte    = is_name_ff ? rd_data_ff : '0;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_summary_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_byte |=> rsp_valid && !rsp_is_name_byte)
      else $error("no summary request after last payload byte");

   a_pending_names_valid: assert property (@(posedge clock) disable iff (reset)
      drain_left_ff != '0 |-> rsp_valid_ff && rsp_name_found)
      else $error("name bytes pending without a valid request in flight");

   a_name_implies_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_name_byte |-> rsp_name_found && rsp_name_length != '0)
      else $error("name byte request without a captured name");

   a_no_run_overlap: assert property (@(posedge clock) disable iff (reset)
      drain_left_ff != '0 |-> !(req_valid && req_ready && req_last_byte))
      else $error("new payload ended while previous name run still draining");

endmodule
